[rtl/core/aedm_pkg.sv]
// Shared types, constants and the microcode table of the adaptive EMA dose meter.
`default_nettype none

package aedm_pkg;

  // Fixed-point limits
  localparam logic [16:0] ONE_Q16  = 17'h1_0000;
  localparam logic [31:0] RATE_MAX = 32'hFFFF_FFFF;
  localparam logic [47:0] DOSE_MAX = 48'hFFFF_FFFF_FFFF;

  // Register reset values
  localparam logic [15:0] RST_RATE_PER_PIXEL = 16'd655;
  localparam logic [15:0] RST_RATE_FLOOR     = 16'd66;
  localparam logic [15:0] RST_ALPHA_LOW      = 16'd3277;
  localparam logic [15:0] RST_ALPHA_HIGH     = 16'd32768;
  localparam logic [31:0] RST_CHANGE_GAIN    = 32'd65536;
  localparam logic [31:0] RST_ALERT_LEVEL    = 32'd196608;
  localparam logic [15:0] RST_FRAME_PERIOD   = 16'd3277;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MEASURING_ENABLED = 3'd0,
    REG_RATE_PER_PIXEL    = 3'd1,
    REG_RATE_FLOOR        = 3'd2,
    REG_ALPHA_LOW         = 3'd3,
    REG_ALPHA_HIGH        = 3'd4,
    REG_CHANGE_GAIN       = 3'd5,
    REG_ALERT_LEVEL       = 3'd6,
    REG_FRAME_PERIOD      = 3'd7
  } cfg_reg_t;

  // Multiplier operand pairs
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_RATE,    // count * rate_per_pixel
    MUL_CHANGE,  // diff * change_gain
    MUL_ALPHA,   // span * change
    MUL_NEW,     // rate * alpha
    MUL_OLD,     // smoothed * (1 - alpha)
    MUL_DOSE     // smoothed * frame_period
  } mul_sel_t;

  // Datapath write-back operations
  typedef enum logic [3:0] {
    WB_NONE,
    WB_RATE,
    WB_DIFF,
    WB_CHANGE,
    WB_ALPHA,
    WB_ACC,
    WB_MIX,
    WB_LOAD,
    WB_DOSE,
    WB_EMIT
  } wb_op_t;

  // Sequencer branch kinds
  typedef enum logic [2:0] {
    JMP_WAIT_IN,
    JMP_NEXT,
    JMP_UNPRIMED,
    JMP_ALWAYS,
    JMP_WAIT_OUT
  } jump_t;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // Program addresses
  localparam step_t STEP_IDLE      = 4'd0;
  localparam step_t STEP_MUL_RATE  = 4'd1;
  localparam step_t STEP_WB_RATE   = 4'd2;
  localparam step_t STEP_DIFF      = 4'd3;
  localparam step_t STEP_MUL_CHG   = 4'd4;
  localparam step_t STEP_WB_CHG    = 4'd5;
  localparam step_t STEP_MUL_ALPHA = 4'd6;
  localparam step_t STEP_WB_ALPHA  = 4'd7;
  localparam step_t STEP_MUL_NEW   = 4'd8;
  localparam step_t STEP_MUL_OLD   = 4'd9;
  localparam step_t STEP_MIX       = 4'd10;
  localparam step_t STEP_LOAD      = 4'd11;
  localparam step_t STEP_MUL_DOSE  = 4'd12;
  localparam step_t STEP_WB_DOSE   = 4'd13;
  localparam step_t STEP_EMIT      = 4'd14;

  typedef struct packed {
    mul_sel_t mul;
    wb_op_t   wb;
    jump_t    jmp;
    step_t    target;
  } ucode_t;

  // Control from sequencer to datapath
  typedef struct packed {
    mul_sel_t mul;
    wb_op_t   wb;
    logic     idle;
  } ctrl_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic start;
    logic primed;
    logic out_free;
  } seq_status_t;

  // Microcode ROM
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t uc;
    unique case (step)
      STEP_IDLE:      uc = '{MUL_NONE,   WB_NONE,   JMP_WAIT_IN,  STEP_IDLE};
      STEP_MUL_RATE:  uc = '{MUL_RATE,   WB_NONE,   JMP_NEXT,     STEP_IDLE};
      STEP_WB_RATE:   uc = '{MUL_NONE,   WB_RATE,   JMP_UNPRIMED, STEP_LOAD};
      STEP_DIFF:      uc = '{MUL_NONE,   WB_DIFF,   JMP_NEXT,     STEP_IDLE};
      STEP_MUL_CHG:   uc = '{MUL_CHANGE, WB_NONE,   JMP_NEXT,     STEP_IDLE};
      STEP_WB_CHG:    uc = '{MUL_NONE,   WB_CHANGE, JMP_NEXT,     STEP_IDLE};
      STEP_MUL_ALPHA: uc = '{MUL_ALPHA,  WB_NONE,   JMP_NEXT,     STEP_IDLE};
      STEP_WB_ALPHA:  uc = '{MUL_NONE,   WB_ALPHA,  JMP_NEXT,     STEP_IDLE};
      STEP_MUL_NEW:   uc = '{MUL_NEW,    WB_NONE,   JMP_NEXT,     STEP_IDLE};
      STEP_MUL_OLD:   uc = '{MUL_OLD,    WB_ACC,    JMP_NEXT,     STEP_IDLE};
      STEP_MIX:       uc = '{MUL_NONE,   WB_MIX,    JMP_ALWAYS,   STEP_MUL_DOSE};
      STEP_LOAD:      uc = '{MUL_NONE,   WB_LOAD,   JMP_NEXT,     STEP_IDLE};
      STEP_MUL_DOSE:  uc = '{MUL_DOSE,   WB_NONE,   JMP_NEXT,     STEP_IDLE};
      STEP_WB_DOSE:   uc = '{MUL_NONE,   WB_DOSE,   JMP_NEXT,     STEP_IDLE};
      STEP_EMIT:      uc = '{MUL_NONE,   WB_EMIT,   JMP_WAIT_OUT, STEP_IDLE};
      default:        uc = '{MUL_NONE,   WB_NONE,   JMP_ALWAYS,   STEP_IDLE};
    endcase
    return uc;
  endfunction

endpackage

`default_nettype wire

[rtl/core/aedm_if.sv]
// Channel interfaces of the adaptive EMA dose meter: samples, results, configuration.
`default_nettype none

interface aedm_sample_if #(
  parameter int COUNT_WIDTH = 20
) ();
  logic                   valid;
  logic                   ready;
  logic [COUNT_WIDTH-1:0] hot_pixel_count;

  modport source (output valid, output hot_pixel_count, input ready);
  modport sink   (input valid, input hot_pixel_count, output ready);
endinterface

interface aedm_result_if ();
  logic        valid;
  logic        ready;
  logic [31:0] filtered_rate;
  logic [47:0] total_dose;
  logic [15:0] alpha_used;
  logic        alert;

  modport source (output valid, output filtered_rate, output total_dose,
                  output alpha_used, output alert, input ready);
  modport sink   (input valid, input filtered_rate, input total_dose,
                  input alpha_used, input alert, output ready);
endinterface

interface aedm_cfg_if ();
  logic                             valid;
  logic                             ready;
  logic [aedm_pkg::CFG_INDEX_W-1:0] index;
  logic [aedm_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/aedm_seq.sv]
// Microcode sequencer: step counter, control ROM and branch logic.
`default_nettype none

module aedm_seq (
  input  wire                       clk,
  input  wire                       rst,
  input  wire aedm_pkg::seq_status_t status,
  output aedm_pkg::ctrl_t           ctrl
);

  aedm_pkg::step_t  step;
  aedm_pkg::step_t  step_next;
  aedm_pkg::ucode_t uc;

  assign uc = aedm_pkg::ucode_rom(step);

  // Next step
  always_comb begin
    unique case (uc.jmp)
      aedm_pkg::JMP_WAIT_IN:  step_next = status.start ? step + 1'b1 : step;
      aedm_pkg::JMP_NEXT:     step_next = step + 1'b1;
      aedm_pkg::JMP_UNPRIMED: step_next = status.primed ? step + 1'b1 : uc.target;
      aedm_pkg::JMP_ALWAYS:   step_next = uc.target;
      aedm_pkg::JMP_WAIT_OUT: step_next = status.out_free ? uc.target : step;
      default:                step_next = aedm_pkg::STEP_IDLE;
    endcase
  end

  // Control word to the datapath
  always_comb begin
    ctrl.mul  = uc.mul;
    ctrl.wb   = uc.wb;
    ctrl.idle = (uc.jmp == aedm_pkg::JMP_WAIT_IN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= aedm_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/adaptive_ema_dose_meter.sv]
// Top level of the adaptive EMA dose meter: registers, datapath and result register.
//
// Usage:
//   samples : one hot-pixel count per camera frame (valid/ready).
//   results : filtered rate, total dose, alpha used and alert (valid/ready).
//   cfg     : register writes, index 0..7, taken in every cycle (ready is high).
//             Write only while the block is idle.
// A count taken while measuring_enabled is 0 is dropped and gives no result.
// Datapath: one shared 32x32 multiplier with a registered product, driven by a
// 15-step microcode program. A count is taken only at the idle step. The first
// count after reset (filter load) goes from the rate write-back straight to the
// load step and skips the alpha and mixing steps; later counts run the whole
// program, and no new count is taken until it returns to the idle step.
// The result sits in an output register; if the receiver stalls, the program
// holds at its final step until the register frees, and no new count is taken.
// Reset (rst, synchronous) restores register defaults, clears filter, dose and
// the first-sample flag, and drops any pending result.
`default_nettype none

module adaptive_ema_dose_meter #(
  parameter int COUNT_WIDTH = 20
) (
  input  wire              clk,
  input  wire              rst,
  aedm_sample_if.sink      samples,
  aedm_result_if.source    results,
  aedm_cfg_if.sink         cfg
);

  // Configuration registers
  logic        measuring_enabled;
  logic [15:0] rate_per_pixel;
  logic [15:0] rate_floor;
  logic [15:0] alpha_low;
  logic [15:0] alpha_high;
  logic [31:0] change_gain;
  logic [31:0] alert_level;
  logic [15:0] frame_period;

  // Datapath registers
  logic [COUNT_WIDTH-1:0] count;
  logic [63:0]            prod;
  logic [31:0]            rate;
  logic [31:0]            diff;
  logic [15:0]            span;
  logic [16:0]            change;
  logic [15:0]            alpha;
  logic [47:0]            acc;
  logic [31:0]            smooth;
  logic [47:0]            dose;
  logic                   primed;
  logic                   out_valid;

  aedm_pkg::ctrl_t       ctrl;
  aedm_pkg::seq_status_t status;

  logic        accept;
  logic        out_free;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [16:0] alpha_comp;
  logic [31:0] rate_sat;
  logic [47:0] mix_sum;
  logic [48:0] dose_sum;

  assign cfg.ready     = 1'b1;
  assign samples.ready = ctrl.idle;
  assign accept        = samples.valid && samples.ready;
  assign out_free      = !out_valid || results.ready;
  assign results.valid = out_valid;

  assign status = '{start: accept && measuring_enabled, primed: primed, out_free: out_free};

  aedm_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      measuring_enabled <= 1'b0;
      rate_per_pixel    <= aedm_pkg::RST_RATE_PER_PIXEL;
      rate_floor        <= aedm_pkg::RST_RATE_FLOOR;
      alpha_low         <= aedm_pkg::RST_ALPHA_LOW;
      alpha_high        <= aedm_pkg::RST_ALPHA_HIGH;
      change_gain       <= aedm_pkg::RST_CHANGE_GAIN;
      alert_level       <= aedm_pkg::RST_ALERT_LEVEL;
      frame_period      <= aedm_pkg::RST_FRAME_PERIOD;
    end else if (cfg.valid && cfg.ready) begin
      unique case (aedm_pkg::cfg_reg_t'(cfg.index))
        aedm_pkg::REG_MEASURING_ENABLED: measuring_enabled <= cfg.data[0];
        aedm_pkg::REG_RATE_PER_PIXEL:    rate_per_pixel    <= cfg.data[15:0];
        aedm_pkg::REG_RATE_FLOOR:        rate_floor        <= cfg.data[15:0];
        aedm_pkg::REG_ALPHA_LOW:         alpha_low         <= cfg.data[15:0];
        aedm_pkg::REG_ALPHA_HIGH:        alpha_high        <= cfg.data[15:0];
        aedm_pkg::REG_CHANGE_GAIN:       change_gain       <= cfg.data[31:0];
        aedm_pkg::REG_ALERT_LEVEL:       alert_level       <= cfg.data[31:0];
        aedm_pkg::REG_FRAME_PERIOD:      frame_period      <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  // Multiplier operand select
  assign alpha_comp = aedm_pkg::ONE_Q16 - {1'b0, alpha};

  always_comb begin
    case (ctrl.mul)
      aedm_pkg::MUL_RATE:   begin mul_a = 32'(count); mul_b = {16'd0, rate_per_pixel}; end
      aedm_pkg::MUL_CHANGE: begin mul_a = diff;       mul_b = change_gain; end
      aedm_pkg::MUL_ALPHA:  begin mul_a = {16'd0, span}; mul_b = {15'd0, change}; end
      aedm_pkg::MUL_NEW:    begin mul_a = rate;       mul_b = {16'd0, alpha}; end
      aedm_pkg::MUL_OLD:    begin mul_a = smooth;     mul_b = {15'd0, alpha_comp}; end
      aedm_pkg::MUL_DOSE:   begin mul_a = smooth;     mul_b = {16'd0, frame_period}; end
      default:              begin mul_a = 32'd0;      mul_b = 32'd0; end
    endcase
  end

  // Shared multiplier, product registered
  always_ff @(posedge clk) begin
    if (ctrl.mul != aedm_pkg::MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
  end

  // Write-back helpers
  always_comb begin
    rate_sat = (prod[63:32] != 32'd0) ? aedm_pkg::RATE_MAX : prod[31:0];
    if (rate_sat < {16'd0, rate_floor}) begin
      rate_sat = {16'd0, rate_floor};
    end
  end

  // blend of two weights summing to 1.0 never exceeds 48 bits
  assign mix_sum  = acc + prod[47:0];
  assign dose_sum = {1'b0, dose} + {17'd0, prod[47:16]};

  // Datapath write-back
  always_ff @(posedge clk) begin
    if (accept) begin
      count <= samples.hot_pixel_count;
    end
    case (ctrl.wb)
      aedm_pkg::WB_RATE: rate <= rate_sat;
      aedm_pkg::WB_DIFF: begin
        diff <= (rate >= smooth) ? rate - smooth : smooth - rate;
        span <= (alpha_high > alpha_low) ? alpha_high - alpha_low : 16'd0;
      end
      aedm_pkg::WB_CHANGE: begin
        change <= (prod[63:16] > 48'(aedm_pkg::ONE_Q16)) ? aedm_pkg::ONE_Q16 : prod[32:16];
      end
      aedm_pkg::WB_ALPHA: alpha <= alpha_low + prod[31:16];
      aedm_pkg::WB_ACC:   acc   <= prod[47:0];
      aedm_pkg::WB_LOAD:  alpha <= alpha_low;
      default: ;
    endcase
  end

  // Filter, dose and first-sample flag
  always_ff @(posedge clk) begin
    if (rst) begin
      smooth <= 32'd0;
      dose   <= 48'd0;
      primed <= 1'b0;
    end else begin
      case (ctrl.wb)
        aedm_pkg::WB_MIX:  smooth <= mix_sum[47:16];
        aedm_pkg::WB_LOAD: begin
          smooth <= rate;
          primed <= 1'b1;
        end
        aedm_pkg::WB_DOSE: dose <= dose_sum[48] ? aedm_pkg::DOSE_MAX : dose_sum[47:0];
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.wb == aedm_pkg::WB_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wb == aedm_pkg::WB_EMIT && out_free) begin
      results.filtered_rate <= smooth;
      results.total_dose    <= dose;
      results.alpha_used    <= alpha;
      results.alert         <= (smooth > alert_level);
    end
  end

`ifndef SYNTHESIS
  // Dose only grows between resets
  a_dose_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> dose >= $past(dose))
    else $error("dose accumulator decreased");

  // The first-sample flag is cleared by reset alone
  a_primed_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !$fell(primed))
    else $error("primed flag fell without reset");

  // A result appears only from the emit step
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.wb == aedm_pkg::WB_EMIT))
    else $error("result register loaded outside emit step");

  // An enabled count starts the program with the rate multiply
  a_start_step: assert property (@(posedge clk) disable iff (rst)
    accept && measuring_enabled |=> ctrl.mul == aedm_pkg::MUL_RATE)
    else $error("sequencer did not start on accepted count");
`endif

endmodule

`default_nettype wire
